### rtl/msp_pkg.sv
// Shared types, widths and constants for the motor speed PID unit.
package msp_pkg;

    localparam int DATA_WIDTH     = 16;
    localparam int GAIN_FRAC_BITS = 4;

    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 16;
    localparam int OLIM_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int ERR_W    = DATA_WIDTH + 1;
    localparam int SUM_W    = ERR_W + 1;
    localparam int SUMRAW_W = SUM_W + 1;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int PP_W     = GAIN_W + 1 + ERR_W;
    localparam int IP_W     = GAIN_W + 1 + SUM_W;
    localparam int DP_W     = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W    = IP_W + 2;
    localparam int SHF_W    = ACC_W - GAIN_FRAC_BITS;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    localparam logic [GAIN_W-1:0]  GAIN_P_RESET         = GAIN_W'(2080);
    localparam logic [GAIN_W-1:0]  GAIN_I_RESET         = GAIN_W'(80);
    localparam logic [GAIN_W-1:0]  GAIN_D_RESET         = GAIN_W'(320);
    localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RESET = LIMIT_W'(200);
    localparam logic [OLIM_W-1:0]  OUTPUT_LIMIT_RESET   = OLIM_W'(7200);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_INTEGRAL_LIMIT = 3'd3,
        REG_OUTPUT_LIMIT   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [LIMIT_W-1:0] integral_limit;
        logic [OLIM_W-1:0]  output_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] speed_setpoint;
        logic signed [DATA_WIDTH-1:0] measured_speed;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] drive;
        logic                         saturated;
    } out_item_t;

    // Work handed from the front end to the multiply/clamp back end.
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
    } mid_item_t;

endpackage

### rtl/msp_front.sv
// Front end: error, clamped integral, derivative term, and the hand-off queue.
module msp_front
    import msp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LIMIT_W-1:0] integral_limit,
    input  logic               push,
    output logic               full,
    input  in_item_t           sample,
    output logic               mid_valid,
    output mid_item_t          mid_item,
    input  logic               mid_pop
);

    logic signed [ERR_W-1:0]    prev_err_reg;
    logic signed [SUM_W-1:0]    error_sum_reg;
    logic signed [ERR_W-1:0]    err;
    logic signed [SUMRAW_W-1:0] sum_raw;
    logic signed [SUMRAW_W-1:0] lim_pos;
    logic signed [SUMRAW_W-1:0] lim_neg;
    logic signed [SUMRAW_W-1:0] sum_cl;
    logic signed [DIFF_W-1:0]   diff;
    logic                       accept;

    mid_item_t                  q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]         wr_ptr_reg;
    logic [Q_PTR_W-1:0]         rd_ptr_reg;
    logic [Q_CNT_W-1:0]         cnt_reg;
    logic [Q_CNT_W-1:0]         cnt_next;

    always_comb
    begin
        err = {sample.speed_setpoint[DATA_WIDTH-1], sample.speed_setpoint}
            - {sample.measured_speed[DATA_WIDTH-1], sample.measured_speed};
        sum_raw = {error_sum_reg[SUM_W-1], error_sum_reg} + {{2{err[ERR_W-1]}}, err};
        lim_pos = SUMRAW_W'(integral_limit);
        lim_neg = -lim_pos;
        if (sum_raw > lim_pos)
        begin
            sum_cl = lim_pos;
        end
        else if (sum_raw < lim_neg)
        begin
            sum_cl = lim_neg;
        end
        else
        begin
            sum_cl = sum_raw;
        end
        diff = {err[ERR_W-1], err} - {prev_err_reg[ERR_W-1], prev_err_reg};
    end

    assign full      = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign accept    = push && !full;
    assign mid_valid = (cnt_reg != '0);
    assign mid_item  = q_mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && !mid_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!accept && mid_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg  <= '0;
            error_sum_reg <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                prev_err_reg  <= err;
                error_sum_reg <= sum_cl[SUM_W-1:0];
                wr_ptr_reg    <= wr_ptr_reg + 1'b1;
            end
            if (mid_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem[wr_ptr_reg] <= '{err: err, sum: sum_cl[SUM_W-1:0], diff: diff};
        end
    end

endmodule

### rtl/msp_back.sv
// Back end: gain products, sum, shift, output clamp and result queue.
module msp_back
    import msp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      mid_valid,
    input  mid_item_t mid_item,
    output logic      mid_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic signed [GAIN_W:0]   gp;
    logic signed [GAIN_W:0]   gi;
    logic signed [GAIN_W:0]   gd;
    logic signed [PP_W-1:0]   p_prod_reg;
    logic signed [IP_W-1:0]   i_prod_reg;
    logic signed [DP_W-1:0]   d_prod_reg;
    logic                     m_valid_reg;
    logic signed [ACC_W-1:0]  acc;
    logic signed [SHF_W-1:0]  shifted;
    logic signed [SHF_W-1:0]  olim_pos;
    logic signed [SHF_W-1:0]  olim_neg;
    logic signed [SHF_W-1:0]  clamped;
    logic                     sat;
    logic                     out_pop;

    out_item_t                q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]       wr_ptr_reg;
    logic [Q_PTR_W-1:0]       rd_ptr_reg;
    logic [Q_CNT_W-1:0]       cnt_reg;
    logic [Q_CNT_W-1:0]       cnt_next;

    assign gp = {1'b0, cfg.gain_p};
    assign gi = {1'b0, cfg.gain_i};
    assign gd = {1'b0, cfg.gain_d};

    // Credit check: the item in the multiply stage always finds a free slot.
    assign mid_pop = mid_valid && ((cnt_reg + Q_CNT_W'(m_valid_reg)) < Q_CNT_W'(Q_DEPTH));

    always_comb
    begin
        acc      = ACC_W'(p_prod_reg) + ACC_W'(i_prod_reg) + ACC_W'(d_prod_reg);
        shifted  = SHF_W'(acc >>> GAIN_FRAC_BITS);
        olim_pos = SHF_W'(cfg.output_limit);
        olim_neg = -olim_pos;
        sat      = 1'b0;
        clamped  = shifted;
        if (shifted > olim_pos)
        begin
            clamped = olim_pos;
            sat     = 1'b1;
        end
        else if (shifted < olim_neg)
        begin
            clamped = olim_neg;
            sat     = 1'b1;
        end
    end

    assign empty   = (cnt_reg == '0);
    assign out_pop = pop && !empty;
    assign result  = q_mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (m_valid_reg && !out_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!m_valid_reg && out_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            m_valid_reg <= mid_pop;
            if (m_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            p_prod_reg <= gp * mid_item.err;
            i_prod_reg <= gi * mid_item.sum;
            d_prod_reg <= gd * mid_item.diff;
        end
        if (m_valid_reg)
        begin
            q_mem[wr_ptr_reg] <= '{drive: clamped[DATA_WIDTH-1:0], saturated: sat};
        end
    end

endmodule

### rtl/motor_speed_pid_unit.sv
// Top level of the motor speed PID unit: register file and front/back ends.
//
//   channel   direction  handshake             payload
//   sample    in         push / full           in_item_t  (target, measured speed)
//   result    out        pop / empty           out_item_t (drive, saturated)
//   config    in         cfg_we                cfg_index, cfg_data
//
// One item per cycle while neither queue stalls; each result passes both queues.
// Error and integral update finish in the front end in the accept cycle; the
// back end registers the three gain products, then sums and clamps them.
// A four-entry queue sits on each side of the back end, so either side may stall.
// Reset clears both queues, the stored error and integral; no clearing pass.
module motor_speed_pid_unit
    import msp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  in_item_t              sample,
    output logic                  empty,
    input  logic                  pop,
    output out_item_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      mid_valid;
    mid_item_t mid_item;
    logic      mid_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= GAIN_P_RESET;
            cfg_reg.gain_i         <= GAIN_I_RESET;
            cfg_reg.gain_d         <= GAIN_D_RESET;
            cfg_reg.integral_limit <= INTEGRAL_LIMIT_RESET;
            cfg_reg.output_limit   <= OUTPUT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_P:         cfg_reg.gain_p         <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:         cfg_reg.gain_i         <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:         cfg_reg.gain_d         <= cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= cfg_data[LIMIT_W-1:0];
                REG_OUTPUT_LIMIT:   cfg_reg.output_limit   <= cfg_data[OLIM_W-1:0];
                default:            ;
            endcase
        end
    end

    msp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .integral_limit (cfg_reg.integral_limit),
        .push           (push),
        .full           (full),
        .sample         (sample),
        .mid_valid      (mid_valid),
        .mid_item       (mid_item),
        .mid_pop        (mid_pop)
    );

    msp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_valid (mid_valid),
        .mid_item  (mid_item),
        .mid_pop   (mid_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

### rtl/msp_checker.sv
// Port-level checks for the motor speed PID unit, bound to the top level.
module msp_checker
    import msp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  push,
    input logic                  full,
    input in_item_t              sample,
    input logic                  empty,
    input logic                  pop,
    input out_item_t             result,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // Clamp is symmetric, so the most negative code never leaves the block.
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.drive != {1'b1, {(DATA_WIDTH-1){1'b0}}}))
        else $error("drive holds the most negative code");

    // Leaving reset both queues are empty.
    a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    // Input queue fills only through an accepted transfer.
    a_full_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without an input transfer");

    // A waiting result holds until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("pending result changed or vanished");

endmodule

bind motor_speed_pid_unit msp_checker u_msp_checker (.*);
